// ----- hdl/floppy_sector_read_sequencer_assert.svh -----
// ----------------------------------------------------------------------------
// floppy sector read sequencer assertion macros
// concurrent assertion shorthands used by the checker
// ----------------------------------------------------------------------------
`ifndef FLOPPY_SECTOR_READ_SEQUENCER_ASSERT_SVH
`define FLOPPY_SECTOR_READ_SEQUENCER_ASSERT_SVH

// assertion on an explicit clock and active-low reset
`define FSRS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fsrs assertion failed");

// assertion on the block clock and reset
`define FSRS_ASSERT_CLK(name, prop) \
  `FSRS_ASSERT(name, clk_i, rst_ni, prop)

`endif

// ----- hdl/fsrs_pkg.sv -----
// ----------------------------------------------------------------------------
// fsrs_pkg
// types, constants and helper functions of the floppy sector read sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsrs_pkg;

  // drive geometry
  localparam int TRACK_SECTORS = 18;
  localparam int SECTOR_BYTES  = 512;

  // field widths
  localparam int LS_W    = 12;
  localparam int OFF_W   = 14;
  localparam int BCNT_W  = 17;
  localparam int TRACK_W = 7;
  localparam int SEC_W   = 5;

  // linear sector split: divide by sectors per cylinder via reciprocal
  localparam int TRACK_DIV   = 2 * TRACK_SECTORS;
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP       = (1 << RECIP_SHIFT) / TRACK_DIV;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int PROD_W      = LS_W + RECIP_W;
  localparam int QD_W        = LS_W + 8;

  // transaction queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // input kinds
  localparam logic [1:0] KIND_JOB    = 2'd0;
  localparam logic [1:0] KIND_IRQ    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // event codes
  localparam logic [1:0] EV_PORT      = 2'd0;
  localparam logic [1:0] EV_DONE      = 2'd1;
  localparam logic [1:0] EV_REJ_WRITE = 2'd2;
  localparam logic [1:0] EV_REJ_BUSY  = 2'd3;

  // controller ports and bytes
  localparam logic [9:0] DOR_PORT   = 10'h3f2;
  localparam logic [9:0] DATA_PORT  = 10'h3f5;
  localparam logic [7:0] MOTOR_ON   = 8'h1c;
  localparam logic [7:0] MOTOR_OFF  = 8'h00;
  localparam logic [7:0] CMD_RECAL  = 8'h07;
  localparam logic [7:0] CMD_SEEK   = 8'h0f;
  localparam logic [7:0] CMD_READ   = 8'he6;
  localparam logic [7:0] SIZE_CODE  = 8'h02;
  localparam logic [7:0] GAP_LEN    = 8'd27;
  localparam logic [7:0] DATA_LEN   = 8'hff;
  localparam logic [7:0] ST_MASK    = 8'hc0;
  localparam logic [7:0] ST_READY   = 8'h80;
  localparam logic [3:0] LEN_RECAL  = 4'd2;
  localparam logic [3:0] LEN_SEEK   = 4'd3;
  localparam logic [3:0] LEN_READ   = 4'd9;

  // dma channel 2 programming
  localparam logic [9:0]  DMA_MODE_PORT = 10'h00b;
  localparam logic [9:0]  DMA_ADDR_PORT = 10'h004;
  localparam logic [9:0]  DMA_PAGE_PORT = 10'h081;
  localparam logic [9:0]  DMA_CNT_PORT  = 10'h005;
  localparam logic [9:0]  DMA_MASK_PORT = 10'h00a;
  localparam logic [7:0]  DMA_MODE_RD   = 8'h46;
  localparam logic [7:0]  DMA_UNMASK    = 8'h02;
  localparam logic [15:0] DMA_COUNT     = 16'(SECTOR_BYTES * TRACK_SECTORS - 1);
  localparam logic [2:0]  DMA_LAST      = 3'd6;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_ON,
    PH_SEND_CAL,
    PH_WAIT_CAL,
    PH_SEND_SEEK,
    PH_WAIT_SEEK,
    PH_SEND_READ,
    PH_WAIT_READ
  } fsrs_phase_e;

  typedef enum logic {
    OP_SINGLE,
    OP_DMA_BURST
  } fsrs_op_e;

  typedef struct packed {
    logic [1:0]      kind;
    logic            is_write;
    logic [LS_W-1:0] linear_sector;
    logic [7:0]      sector_count;
    logic [7:0]      status_byte;
  } fsrs_in_t;

  typedef struct packed {
    logic [9:0]        port_address;
    logic [7:0]        port_data;
    logic [1:0]        event_code;
    logic [OFF_W-1:0]  buffer_offset;
    logic [BCNT_W-1:0] byte_count;
    logic              last;
  } fsrs_out_t;

  typedef struct packed {
    fsrs_op_e          op;
    logic [9:0]        port_address;
    logic [7:0]        port_data;
    logic [1:0]        event_code;
    logic [OFF_W-1:0]  buffer_offset;
    logic [BCNT_W-1:0] byte_count;
  } fsrs_entry_t;

  // port of one dma programming write
  function automatic logic [9:0] dma_addr(input logic [2:0] idx);
    logic [9:0] a;
    case (idx)
      3'd0:          a = DMA_MODE_PORT;
      3'd1, 3'd2:    a = DMA_ADDR_PORT;
      3'd3:          a = DMA_PAGE_PORT;
      3'd4, 3'd5:    a = DMA_CNT_PORT;
      default:       a = DMA_MASK_PORT;
    endcase
    return a;
  endfunction

  // data of one dma programming write
  function automatic logic [7:0] dma_data(input logic [2:0] idx);
    logic [7:0] d;
    case (idx)
      3'd0:    d = DMA_MODE_RD;
      3'd4:    d = DMA_COUNT[7:0];
      3'd5:    d = DMA_COUNT[15:8];
      3'd6:    d = DMA_UNMASK;
      default: d = 8'h00;
    endcase
    return d;
  endfunction

endpackage

// ----- hdl/fsrs_fifo.sv -----
// ----------------------------------------------------------------------------
// fsrs_fifo
// short transaction queue between the classifying front and the output back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsrs_fifo import fsrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  fsrs_entry_t data_i,
  output logic        full_o,
  input  logic        pop_i,
  output fsrs_entry_t data_o,
  output logic        empty_o
);

  fsrs_entry_t           mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/fsrs_front.sv -----
// ----------------------------------------------------------------------------
// fsrs_front
// accepts events, runs the job phase machine and queues result transactions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsrs_front import fsrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  fsrs_in_t    item_i,
  output logic        full_o,
  output logic        q_push_o,
  output fsrs_entry_t q_data_o,
  input  logic        q_full_i
);

  fsrs_phase_e         phase_q, phase_d;
  logic [3:0]          idx_q, idx_d;
  logic [3:0]          idx_next;
  logic                head_q;
  logic [TRACK_W-1:0]  track_q;
  logic [SEC_W-1:0]    sec_q;
  logic [7:0]          job_cnt_q, job_cnt_d;

  // sector split unit
  logic [1:0]          conv_stage_q;
  logic [LS_W-1:0]     ls_q;
  logic [PROD_W-1:0]   prod_q;
  logic [LS_W-1:0]     quo0, quo1;
  logic [QD_W-1:0]     quo_mul;
  logic [LS_W-1:0]     rem0, rem1, rem_sec;
  logic                head_new;
  logic                conv_start;

  logic                accept;
  logic                sending;
  logic                status_ready;
  fsrs_entry_t         ent;
  logic                ent_valid;

  // phase reached once a command is fully sent
  function automatic fsrs_phase_e after_send(input fsrs_phase_e ph);
    fsrs_phase_e n;
    case (ph)
      PH_SEND_CAL:  n = PH_WAIT_CAL;
      PH_SEND_SEEK: n = PH_WAIT_SEEK;
      default:      n = PH_WAIT_READ;
    endcase
    return n;
  endfunction

  // number of bytes in the command of a send phase
  function automatic logic [3:0] phase_len(input fsrs_phase_e ph);
    logic [3:0] l;
    case (ph)
      PH_SEND_CAL:  l = LEN_RECAL;
      PH_SEND_SEEK: l = LEN_SEEK;
      default:      l = LEN_READ;
    endcase
    return l;
  endfunction

  // command byte at a position of the current command
  function automatic logic [7:0] cmd_byte(input fsrs_phase_e ph, input logic [3:0] idx,
                                          input logic hd, input logic [TRACK_W-1:0] trk);
    logic [7:0] b;
    logic [7:0] hd_b;
    hd_b = {5'd0, hd, 2'd0};
    if (ph == PH_SEND_CAL) begin
      b = CMD_RECAL;
    end else if (ph == PH_SEND_SEEK) begin
      case (idx)
        4'd0:    b = CMD_SEEK;
        4'd1:    b = hd_b;
        default: b = {1'b0, trk};
      endcase
    end else begin
      case (idx)
        4'd0:    b = CMD_READ;
        4'd1:    b = hd_b;
        4'd2:    b = {1'b0, trk};
        4'd3:    b = {7'd0, hd};
        4'd4:    b = 8'd1;
        4'd5:    b = SIZE_CODE;
        4'd6:    b = 8'(TRACK_SECTORS);
        4'd7:    b = GAP_LEN;
        default: b = DATA_LEN;
      endcase
    end
    return b;
  endfunction

  assign full_o       = q_full_i || (conv_stage_q != 2'd0);
  assign accept       = push_i && !full_o;
  assign sending      = phase_q inside {PH_SEND_CAL, PH_SEND_SEEK, PH_SEND_READ};
  assign status_ready = ((item_i.status_byte & ST_MASK) == ST_READY);
  assign idx_next     = idx_q + 1'b1;

  // classify the event, advance the phase and build the transaction
  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    job_cnt_d  = job_cnt_q;
    ent        = '0;
    ent_valid  = 1'b0;
    conv_start = 1'b0;
    if (accept) begin
      case (item_i.kind)
        KIND_JOB: begin
          ent_valid = 1'b1;
          if (phase_q != PH_IDLE) begin
            ent.event_code = EV_REJ_BUSY;
          end else if (item_i.is_write) begin
            ent.event_code = EV_REJ_WRITE;
          end else begin
            ent.port_address = DOR_PORT;
            ent.port_data    = MOTOR_ON;
            ent.event_code   = EV_PORT;
            job_cnt_d        = item_i.sector_count;
            idx_d            = '0;
            phase_d          = PH_WAIT_ON;
            conv_start       = 1'b1;
          end
        end
        KIND_IRQ: begin
          case (phase_q)
            PH_WAIT_ON: begin
              phase_d = PH_SEND_CAL;
              idx_d   = '0;
            end
            PH_WAIT_CAL: begin
              phase_d = PH_SEND_SEEK;
              idx_d   = '0;
            end
            PH_WAIT_SEEK: begin
              ent_valid  = 1'b1;
              ent.op     = OP_DMA_BURST;
              phase_d    = PH_SEND_READ;
              idx_d      = '0;
            end
            PH_WAIT_READ: begin
              ent_valid         = 1'b1;
              ent.port_address  = DOR_PORT;
              ent.port_data     = MOTOR_OFF;
              ent.event_code    = EV_DONE;
              ent.buffer_offset = OFF_W'(SECTOR_BYTES) * (OFF_W'(sec_q) - OFF_W'(1));
              ent.byte_count    = BCNT_W'(SECTOR_BYTES) * BCNT_W'(job_cnt_q);
              phase_d           = PH_IDLE;
              idx_d             = '0;
            end
            default: ;
          endcase
        end
        KIND_STATUS: begin
          if (sending && status_ready) begin
            ent_valid        = 1'b1;
            ent.port_address = DATA_PORT;
            ent.port_data    = cmd_byte(phase_q, idx_q, head_q, track_q);
            ent.event_code   = EV_PORT;
            if (idx_next >= phase_len(phase_q)) begin
              phase_d = after_send(phase_q);
              idx_d   = '0;
            end else begin
              idx_d = idx_next;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign q_push_o = ent_valid;
  assign q_data_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      idx_q     <= '0;
      job_cnt_q <= '0;
    end else begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      job_cnt_q <= job_cnt_d;
    end
  end

  // sector split: quotient estimate, then one correction step
  assign quo0     = LS_W'(prod_q >> RECIP_SHIFT);
  assign quo_mul  = QD_W'(quo0) * QD_W'(TRACK_DIV);
  assign rem0     = ls_q - quo_mul[LS_W-1:0];
  assign quo1     = (rem0 >= LS_W'(TRACK_DIV)) ? quo0 + 1'b1 : quo0;
  assign rem1     = (rem0 >= LS_W'(TRACK_DIV)) ? rem0 - LS_W'(TRACK_DIV) : rem0;
  assign head_new = (rem1 >= LS_W'(TRACK_SECTORS));
  assign rem_sec  = (head_new ? rem1 - LS_W'(TRACK_SECTORS) : rem1) + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_stage_q <= 2'd0;
      head_q       <= 1'b0;
      track_q      <= '0;
      sec_q        <= '0;
    end else begin
      case (conv_stage_q)
        2'd0: begin
          if (conv_start) begin
            conv_stage_q <= 2'd1;
          end
        end
        2'd1: begin
          conv_stage_q <= 2'd2;
        end
        default: begin
          conv_stage_q <= 2'd0;
          head_q       <= head_new;
          track_q      <= quo1[TRACK_W-1:0];
          sec_q        <= rem_sec[SEC_W-1:0];
        end
      endcase
    end
  end

  // sector split operands
  always_ff @(posedge clk_i) begin
    if (conv_start) begin
      ls_q <= item_i.linear_sector;
    end
    prod_q <= PROD_W'(ls_q) * PROD_W'(RECIP);
  end

endmodule

// ----- hdl/fsrs_back.sv -----
// ----------------------------------------------------------------------------
// fsrs_back
// expands queued transactions into result items behind an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsrs_back import fsrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fsrs_entry_t q_data_i,
  input  logic        q_empty_i,
  output logic        q_pop_o,
  output fsrs_out_t   item_o,
  output logic        empty_o,
  input  logic        pop_i
);

  fsrs_out_t  out_q, out_d;
  logic       out_valid_q, out_valid_d;
  logic [2:0] sub_q, sub_d;
  logic       load;

  assign load    = !out_valid_q || pop_i;
  assign empty_o = !out_valid_q;
  assign item_o  = out_q;

  // next result from the queue head, one dma write per cycle unless the output register is held
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    sub_d       = sub_q;
    q_pop_o     = 1'b0;
    if (load) begin
      out_valid_d = !q_empty_i;
      if (!q_empty_i) begin
        out_d.port_address  = q_data_i.port_address;
        out_d.port_data     = q_data_i.port_data;
        out_d.event_code    = q_data_i.event_code;
        out_d.buffer_offset = q_data_i.buffer_offset;
        out_d.byte_count    = q_data_i.byte_count;
        out_d.last          = 1'b1;
        if (q_data_i.op == OP_DMA_BURST) begin
          out_d.port_address = dma_addr(sub_q);
          out_d.port_data    = dma_data(sub_q);
        end
        if (q_data_i.op == OP_DMA_BURST && sub_q != DMA_LAST) begin
          out_d.last = 1'b0;
          sub_d      = sub_q + 1'b1;
        end else begin
          q_pop_o = 1'b1;
          sub_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sub_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      sub_q       <= sub_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ----- hdl/floppy_sector_read_sequencer.sv -----
// ----------------------------------------------------------------------------
// floppy_sector_read_sequencer
// drives a pc-style floppy controller through one sector read job
// ----------------------------------------------------------------------------
// Events enter on a queue-style port (push/full): job requests, controller
// interrupts and main status samples. Results leave on a queue-style port
// (empty/pop): port writes, a done report, or a reject, with last marking
// the final result of each event.
// The first result of an event passes through the queue and then the output
// register. One event per cycle while full is low and one result per cycle
// while the receiver pops. The seek interrupt yields seven dma writes, which
// the output stage emits one by one while the input keeps accepting until the
// four-entry queue fills. An accepted read job holds full high while the
// two-stage reciprocal multiplier splits the sector number into head, track
// and sector.
// Reset puts the job in idle with no results pending.
// When the receiver stops popping, results wait in the output register and
// the queue; full rises once the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module floppy_sector_read_sequencer import fsrs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  fsrs_in_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output fsrs_out_t out_item_o
);

  fsrs_entry_t q_wdata, q_rdata;
  logic        q_push, q_full, q_pop, q_empty;

  // event classification and phase machine
  fsrs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (in_item_i),
    .full_o   (full),
    .q_push_o (q_push),
    .q_data_o (q_wdata),
    .q_full_i (q_full)
  );

  // decoupling queue
  fsrs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // result expansion and output register
  fsrs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_data_i  (q_rdata),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .item_o    (out_item_o),
    .empty_o   (empty),
    .pop_i     (pop)
  );

endmodule

// ----- hdl/fsrs_checker.sv -----
// ----------------------------------------------------------------------------
// fsrs_checker
// port-level checks of the floppy sector read sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "floppy_sector_read_sequencer_assert.svh"

module fsrs_checker import fsrs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input fsrs_in_t  in_item_i,
  input logic      empty,
  input logic      pop,
  input fsrs_out_t out_item_o
);

  // a waiting result stays until taken
  `FSRS_ASSERT_CLK(a_result_held, !empty && !pop |=> !empty)

  // a waiting result does not change
  `FSRS_ASSERT_CLK(a_result_stable, !empty && !pop |=> $stable(out_item_o))

  // rejects write no port and end their event
  `FSRS_ASSERT_CLK(a_reject_shape, !empty && (out_item_o.event_code == EV_REJ_WRITE || out_item_o.event_code == EV_REJ_BUSY) |-> out_item_o.port_address == 10'd0 && out_item_o.port_data == 8'd0 && out_item_o.last)

  // offset and count only travel with a done report
  `FSRS_ASSERT_CLK(a_done_fields, !empty && out_item_o.event_code != EV_DONE |-> out_item_o.buffer_offset == '0 && out_item_o.byte_count == '0)

endmodule

bind floppy_sector_read_sequencer fsrs_checker u_fsrs_checker (.*);

// ----- test/fsrs_port_monitor.sv -----
// ----------------------------------------------------------------------------
// fsrs_port_monitor
// watches both queue ports of the floppy read sequencer and checks results
// ----------------------------------------------------------------------------
// Each event accepted on the input side is run through a behavioural copy of
// the job sequencer, which queues the port writes, done reports and rejects
// that the event should produce. Each result popped on the output side is
// compared field by field with the oldest queued one. Mismatches and
// unexpected results are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsrs_port_monitor import fsrs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  logic      full,
  input  fsrs_in_t  in_item,
  input  logic      empty,
  input  logic      pop,
  input  fsrs_out_t out_item,
  output int        mismatch_count,
  output int        due_count
);

  // sector field of the read command always starts the track
  localparam logic [7:0] FIRST_SECTOR = 8'd1;

  // job state
  fsrs_phase_e job_phase;
  logic [3:0]  cmd_idx;
  logic        head_sel;
  logic [6:0]  track_no;
  logic [4:0]  first_sect;
  logic [7:0]  sect_total;

  // results still to come, and the ones caused by the current transaction
  fsrs_out_t   due_q[$];
  fsrs_out_t   step_q[$];

  function automatic void add_result(input logic [9:0] addr, input logic [7:0] data,
                                     input logic [1:0] code,
                                     input logic [OFF_W-1:0] offs,
                                     input logic [BCNT_W-1:0] bytes);
    fsrs_out_t r;
    r = '0;
    r.port_address  = addr;
    r.port_data     = data;
    r.event_code    = code;
    r.buffer_offset = offs;
    r.byte_count    = bytes;
    step_q.push_back(r);
  endfunction

  // number of bytes in the command being sent
  function automatic logic [3:0] command_len(input fsrs_phase_e ph);
    case (ph)
      PH_SEND_CAL:  return LEN_RECAL;
      PH_SEND_SEEK: return LEN_SEEK;
      default:      return LEN_READ;
    endcase
  endfunction

  // next controller command byte for the current phase
  function automatic logic [7:0] command_byte();
    logic [7:0] hd;
    hd = {5'd0, head_sel, 2'b00};
    if (job_phase == PH_SEND_CAL) return CMD_RECAL;
    if (job_phase == PH_SEND_SEEK) begin
      case (cmd_idx)
        4'd0:    return CMD_SEEK;
        4'd1:    return hd;
        default: return {1'b0, track_no};
      endcase
    end
    case (cmd_idx)
      4'd0:    return CMD_READ;
      4'd1:    return hd;
      4'd2:    return {1'b0, track_no};
      4'd3:    return {7'd0, head_sel};
      4'd4:    return FIRST_SECTOR;
      4'd5:    return SIZE_CODE;
      4'd6:    return 8'(TRACK_SECTORS);
      4'd7:    return GAP_LEN;
      default: return DATA_LEN;
    endcase
  endfunction

  // step the job for one accepted transaction and queue what it produces
  task automatic advance_job(input fsrs_in_t it);
    int        ls;
    fsrs_out_t r;
    ls = int'(it.linear_sector);
    step_q.delete();
    case (it.kind)
      KIND_JOB: begin
        if (job_phase != PH_IDLE) begin
          add_result('0, '0, EV_REJ_BUSY, '0, '0);
        end else if (it.is_write) begin
          add_result('0, '0, EV_REJ_WRITE, '0, '0);
        end else begin
          head_sel   = 1'((ls % (2 * TRACK_SECTORS)) / TRACK_SECTORS);
          track_no   = 7'(ls / (2 * TRACK_SECTORS));
          first_sect = 5'(ls % TRACK_SECTORS + 1);
          sect_total = it.sector_count;
          cmd_idx    = '0;
          job_phase  = PH_WAIT_ON;
          add_result(DOR_PORT, MOTOR_ON, EV_PORT, '0, '0);
        end
      end
      KIND_IRQ: begin
        case (job_phase)
          PH_WAIT_ON: begin
            job_phase = PH_SEND_CAL;
            cmd_idx   = '0;
          end
          PH_WAIT_CAL: begin
            job_phase = PH_SEND_SEEK;
            cmd_idx   = '0;
          end
          PH_WAIT_SEEK: begin
            // dma channel 2 set up for a whole track
            add_result(DMA_MODE_PORT, DMA_MODE_RD, EV_PORT, '0, '0);
            add_result(DMA_ADDR_PORT, 8'h00, EV_PORT, '0, '0);
            add_result(DMA_ADDR_PORT, 8'h00, EV_PORT, '0, '0);
            add_result(DMA_PAGE_PORT, 8'h00, EV_PORT, '0, '0);
            add_result(DMA_CNT_PORT, DMA_COUNT[7:0], EV_PORT, '0, '0);
            add_result(DMA_CNT_PORT, DMA_COUNT[15:8], EV_PORT, '0, '0);
            add_result(DMA_MASK_PORT, DMA_UNMASK, EV_PORT, '0, '0);
            job_phase = PH_SEND_READ;
            cmd_idx   = '0;
          end
          PH_WAIT_READ: begin
            add_result(DOR_PORT, MOTOR_OFF, EV_DONE,
                       OFF_W'(SECTOR_BYTES * (int'(first_sect) - 1)),
                       BCNT_W'(SECTOR_BYTES * int'(sect_total)));
            job_phase = PH_IDLE;
            cmd_idx   = '0;
          end
          default: ;
        endcase
      end
      KIND_STATUS: begin
        if ((job_phase == PH_SEND_CAL || job_phase == PH_SEND_SEEK ||
             job_phase == PH_SEND_READ) && (it.status_byte & ST_MASK) == ST_READY) begin
          add_result(DATA_PORT, command_byte(), EV_PORT, '0, '0);
          cmd_idx = cmd_idx + 4'd1;
          if (cmd_idx >= command_len(job_phase)) begin
            job_phase = fsrs_phase_e'(job_phase + 3'd1);
            cmd_idx   = '0;
          end
        end
      end
      default: ;
    endcase
    // mark the final result of this transaction
    if (step_q.size() > 0) begin
      r      = step_q.pop_back();
      r.last = 1'b1;
      step_q.push_back(r);
    end
    foreach (step_q[i]) due_q.push_back(step_q[i]);
  endtask

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result(input fsrs_out_t got);
    fsrs_out_t want;
    if (due_q.size() == 0) begin
      $error("unexpected result: port 0x%0h data 0x%0h event %0d",
             got.port_address, got.port_data, got.event_code);
      mismatch_count++;
    end else begin
      want = due_q.pop_front();
      compare_field("port_address", want.port_address, got.port_address);
      compare_field("port_data", want.port_data, got.port_data);
      compare_field("event_code", want.event_code, got.event_code);
      compare_field("buffer_offset", want.buffer_offset, got.buffer_offset);
      compare_field("byte_count", want.byte_count, got.byte_count);
      compare_field("last", want.last, got.last);
    end
  endtask

  // results are checked before the new transaction is predicted, so a
  // result can never be matched against an event accepted on the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_phase      = PH_IDLE;
      cmd_idx        = '0;
      head_sel       = 1'b0;
      track_no       = '0;
      first_sect     = '0;
      sect_total     = '0;
      due_q.delete();
      mismatch_count = 0;
      due_count      = 0;
    end else begin
      if (pop && !empty) check_result(out_item);
      if (push && !full) advance_job(in_item);
      due_count = due_q.size();
    end
  end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// testbench for the floppy sector read sequencer
// ----------------------------------------------------------------------------
// Drives job requests, controller interrupts and status samples into the
// sequencer: first a directed job covering rejects, ignored events and the
// extreme sector numbers, then random read jobs with random start sectors
// and counts, mixed with stray and malformed events. The sender works in
// bursts with random gaps unless steady, the receiver stalls in changing
// patterns, and the port monitor predicts and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import fsrs_pkg::*; ();

  localparam int         JOB_ITEMS    = 360;
  localparam int         DRAIN_CYCLES = 20;
  localparam longint     TIMEOUT_NS   = 64'd20_000_000;
  localparam logic [1:0] KIND_SPARE   = 2'd3;
  localparam int         LAST_SECTOR  = 2879;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  fsrs_in_t  in_item;
  logic      empty;
  logic      pop;
  fsrs_out_t out_item;
  int        fail_count;
  int        due_count;

  int        burst_left;
  int        useful_items;
  bit        steady;

  floppy_sector_read_sequencer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  fsrs_port_monitor u_port_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .in_item        (in_item),
    .empty          (empty),
    .pop            (pop),
    .out_item       (out_item),
    .mismatch_count (fail_count),
    .due_count      (due_count)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS * 1ns);
    $display("tb_top NOT OK");
    $finish;
  end

  // receiver: the stall pattern is chosen at random and changed after a random run
  initial begin : receiver
    int mode_left;
    int stall_mode;
    mode_left  = 0;
    stall_mode = 0;
    pop        = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 300);
      end
      mode_left--;
      case (stall_mode)
        0:       pop <= 1'b1;
        1:       pop <= ($urandom_range(0, 1) == 1);
        2:       pop <= ($urandom_range(0, 7) != 0);
        default: pop <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // event builders, every unused field carries random bits
  function automatic fsrs_in_t any_item();
    return fsrs_in_t'(31'($urandom));
  endfunction

  function automatic fsrs_in_t job_req(input bit wr, input int ls, input int cnt);
    fsrs_in_t r;
    r               = any_item();
    r.kind          = KIND_JOB;
    r.is_write      = wr;
    r.linear_sector = LS_W'(ls);
    r.sector_count  = 8'(cnt);
    return r;
  endfunction

  function automatic fsrs_in_t irq_item();
    fsrs_in_t r;
    r      = any_item();
    r.kind = KIND_IRQ;
    return r;
  endfunction

  function automatic fsrs_in_t spare_item();
    fsrs_in_t r;
    r      = any_item();
    r.kind = KIND_SPARE;
    return r;
  endfunction

  // status sample with the ready pattern in the top bits, or any other one
  function automatic fsrs_in_t status_item(input bit ready);
    fsrs_in_t   r;
    logic [1:0] top_bits;
    r        = any_item();
    r.kind   = KIND_STATUS;
    top_bits = 2'($urandom_range(0, 2));
    if (top_bits == 2'b10) top_bits = 2'b11;
    r.status_byte[7:6] = ready ? 2'b10 : top_bits;
    return r;
  endfunction

  function automatic int rand_sector();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return (1 << LS_W) - 1;
      2:       return $urandom_range(LAST_SECTOR + 1, (1 << LS_W) - 1);
      default: return $urandom_range(0, LAST_SECTOR);
    endcase
  endfunction

  function automatic int rand_count();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // one transaction; called and returns at a falling edge, push left high
  task automatic send(input fsrs_in_t it, input bit useful);
    if (burst_left == 0) begin
      if (!steady) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
    if (useful) useful_items++;
  endtask

  // hold off until every outstanding result has been popped
  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk_i); while (due_count != 0);
  endtask

  // stray event that the block should ignore or reject
  task automatic add_noise(input bit noisy, input bit sending);
    if (noisy && $urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 5))
        0: send(status_item(1'b0), 1'b0);
        1: send(spare_item(), 1'b0);
        2: send(job_req(1'($urandom_range(0, 1)), rand_sector(), rand_count()), 1'b1);
        3: begin
          if (sending) send(irq_item(), 1'b0);
          else send(status_item(1'b1), 1'b0);
        end
        4: send(any_item(), 1'b0);
        default: send(status_item(1'b0), 1'b0);
      endcase
    end
  endtask

  task automatic send_irq(input bit noisy);
    add_noise(noisy, 1'b0);
    send(irq_item(), 1'b1);
  endtask

  task automatic send_bytes(input logic [3:0] n, input bit noisy);
    repeat (int'(n)) begin
      add_noise(noisy, 1'b1);
      send(status_item(1'b1), 1'b1);
    end
  endtask

  // full read job: motor on, recalibrate, seek, dma and read, done
  task automatic run_job(input int ls, input int cnt, input bit noisy);
    send(job_req(1'b0, ls, cnt), 1'b1);
    send_irq(noisy);
    send_bytes(LEN_RECAL, noisy);
    send_irq(noisy);
    send_bytes(LEN_SEEK, noisy);
    send_irq(noisy);
    send_bytes(LEN_READ, noisy);
    send_irq(noisy);
  endtask

  // stimulus and verdict
  initial begin
    rst_ni       = 1'b0;
    push         = 1'b0;
    in_item      = '0;
    burst_left   = 0;
    useful_items = 0;
    steady       = 1'b1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed job with the corner cases around it
    send(job_req(1'b1, (1 << LS_W) - 1, 255), 1'b1);   // write rejected while idle
    send(irq_item(), 1'b0);                             // stray interrupt while idle
    send(status_item(1'b1), 1'b0);                      // nothing to send yet
    send(spare_item(), 1'b0);
    send(job_req(1'b0, LAST_SECTOR, 255), 1'b1);        // last sector, head 1
    send(job_req(1'b0, 0, 0), 1'b1);                    // busy
    send(job_req(1'b1, 0, 0), 1'b1);                    // busy beats write reject
    send(status_item(1'b1), 1'b0);                      // still waiting for spin-up
    send_irq(1'b0);
    send(irq_item(), 1'b0);                             // interrupt with bytes pending
    send(status_item(1'b0), 1'b0);                      // controller not ready
    send_bytes(LEN_RECAL, 1'b0);
    send_irq(1'b0);
    send_bytes(LEN_SEEK, 1'b0);
    send_irq(1'b0);
    send_bytes(LEN_READ, 1'b0);
    send_irq(1'b0);
    wait_drained();

    // random jobs
    while (useful_items < JOB_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) send(job_req(1'b1, rand_sector(), rand_count()), 1'b1);
      run_job(rand_sector(), rand_count(), $urandom_range(0, 2) != 0);
      if ($urandom_range(0, 4) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && due_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- floppy_sector_read_sequencer.f -----
+incdir+hdl
hdl/fsrs_pkg.sv
hdl/fsrs_fifo.sv
hdl/fsrs_front.sv
hdl/fsrs_back.sv
hdl/floppy_sector_read_sequencer.sv
hdl/fsrs_checker.sv
test/fsrs_port_monitor.sv
test/tb_top.sv
